// ===== hdl/arlt_pkg.sv =====
// Shared types and constants of the address region lookup table.
package arlt_pkg;

    localparam int ENTRIES = 64;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_UNLOAD = 2'd1;
    localparam logic [1:0] OP_LOOKUP = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] handle;
        logic [31:0] region_base;
        logic [31:0] region_size;
        logic [31:0] address;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] found_handle;
        logic [31:0] offset;
    } t_out_item;

    typedef struct packed {
        logic [31:0] handle;
        logic [31:0] base;
        logic [31:0] size;
    } t_slot;

    typedef struct packed {
        logic             start;
        logic             step;
        logic [IDX_W-1:0] idx;
        logic             finish;
    } t_dp_cmd;

    typedef struct packed {
        logic out_busy;
    } t_dp_sts;

endpackage

// ===== hdl/arlt_ctrl.sv =====
// Sequencer that walks the slots once per item and releases the result.
module arlt_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  arlt_pkg::t_dp_sts i_sts,
    output arlt_pkg::t_dp_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_FINISH
    } t_state;

    t_state                     r_state;
    logic [arlt_pkg::IDX_W-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    r_cnt <= '0;
                    if (i_in_valid) begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_cnt == arlt_pkg::IDX_W'(arlt_pkg::ENTRIES - 1)) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_DRAIN: begin
                    r_state <= S_FINISH;
                end
                S_FINISH: begin
                    if (!i_sts.out_busy) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_cmd.start  = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.step   = (r_state == S_SCAN);
    assign o_cmd.idx    = r_cnt;
    assign o_cmd.finish = (r_state == S_FINISH) && !i_sts.out_busy;

endmodule

// ===== hdl/arlt_dp.sv =====
// Slot store, compare stage, best-match tracking and output register.
module arlt_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  arlt_pkg::t_in_item  i_in_item,
    input  arlt_pkg::t_dp_cmd   i_cmd,
    output arlt_pkg::t_dp_sts   o_sts,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output arlt_pkg::t_out_item o_out_item
);

    arlt_pkg::t_slot            r_mem [arlt_pkg::ENTRIES];
    logic [arlt_pkg::ENTRIES-1:0] r_valid;

    arlt_pkg::t_in_item         r_item;
    arlt_pkg::t_slot            r_rd_data;
    logic [arlt_pkg::IDX_W-1:0] r_rd_idx;
    logic                       r_rd_vld;

    logic                       r_flag;
    logic [31:0]                r_best_base;
    logic [31:0]                r_best_handle;

    logic                       r_out_valid;
    arlt_pkg::t_out_item        r_out;

    logic                       slot_live;
    logic [32:0]                slot_end;
    logic                       slot_hit;
    logic                       do_load;
    logic                       do_unload;
    logic                       do_best;
    arlt_pkg::t_out_item        n_out;
    logic                       n_out_valid;

    assign slot_live = r_rd_vld && r_valid[r_rd_idx];
    assign slot_end  = {1'b0, r_rd_data.base} + {1'b0, r_rd_data.size};
    assign slot_hit  = (r_rd_data.base <= r_item.address)
                    && ({1'b0, r_item.address} <= slot_end);

    assign do_load   = r_rd_vld && !r_valid[r_rd_idx] && !r_flag
                    && (r_item.opcode == arlt_pkg::OP_LOAD);
    assign do_unload = slot_live && (r_item.opcode == arlt_pkg::OP_UNLOAD)
                    && (r_rd_data.handle == r_item.handle);
    assign do_best   = slot_live && (r_item.opcode == arlt_pkg::OP_LOOKUP) && slot_hit
                    && (!r_flag || (r_rd_data.base < r_best_base));

    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            r_rd_data <= r_mem[i_cmd.idx];
        end
        if (do_load) begin
            r_mem[r_rd_idx] <= '{handle: r_item.handle,
                                 base:   r_item.region_base,
                                 size:   r_item.region_size};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.step;
            if (do_load) begin
                r_valid[r_rd_idx] <= 1'b1;
            end else if (do_unload) begin
                r_valid[r_rd_idx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx <= i_cmd.idx;
        if (i_cmd.start) begin
            r_item <= i_in_item;
            r_flag <= 1'b0;
        end else if (do_load || do_unload || do_best) begin
            r_flag <= 1'b1;
        end
        if (do_best) begin
            r_best_base   <= r_rd_data.base;
            r_best_handle <= r_rd_data.handle;
        end
    end

    always_comb begin
        n_out = '{status: arlt_pkg::ST_MISS, found_handle: 32'd0, offset: 32'd0};
        unique case (r_item.opcode)
            arlt_pkg::OP_LOAD: begin
                n_out.status = r_flag ? arlt_pkg::ST_OK : arlt_pkg::ST_FULL;
            end
            arlt_pkg::OP_UNLOAD: begin
                n_out.status = r_flag ? arlt_pkg::ST_OK : arlt_pkg::ST_MISS;
            end
            arlt_pkg::OP_LOOKUP: begin
                if (r_flag) begin
                    n_out.status       = arlt_pkg::ST_OK;
                    n_out.found_handle = r_best_handle;
                    n_out.offset       = r_item.address - r_best_base;
                end
            end
            default: begin
                n_out.status = arlt_pkg::ST_MISS;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid && i_out_stall;
        if (i_cmd.finish) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
        if (i_cmd.finish) begin
            r_out <= n_out;
        end
    end

    assign o_sts.out_busy = r_out_valid && i_out_stall;
    assign o_out_valid    = r_out_valid;
    assign o_out_item     = r_out;

endmodule

// ===== hdl/address_region_lookup_table.sv =====
// Top level of the address region lookup table.
//
// Holds up to ENTRIES (64) regions of handle, base and size. Every item, load,
// unload or lookup, walks all slots once through a single registered read
// port of the slot store and one compare stage. The result of an item is
// registered before the next item is taken, and a new item is taken while the
// previous result still waits at the output.
// Load fills the lowest free slot and reports full when none is free, unload
// drops every slot with the handle, lookup returns the handle and offset of
// the hit with the lowest base (ties to the lowest slot) over base to
// base + size inclusive, computed without wrap. Slot valid bits clear at
// reset; no clearing pass is needed.
module address_region_lookup_table (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  arlt_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output arlt_pkg::t_out_item o_out_item
);

    arlt_pkg::t_dp_cmd cmd;
    arlt_pkg::t_dp_sts sts;

    arlt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    arlt_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

// ===== tb/address_region_lookup_table_test.sv =====
// Self-checking testbench of the address region lookup table: directed table, then random phases.
`timescale 1ns / 1ps

module address_region_lookup_table_test;

    localparam logic [1:0] OP_SPARE      = 2'd3;
    localparam int         RANDOM_ITEMS  = 950;
    localparam int         CYCLE_LIMIT   = 800000;
    localparam int         SETTLE_CYCLES = 80;
    localparam int         NUM_DIRECTED  = 23;

    localparam arlt_pkg::t_out_item RES_DONE = '{arlt_pkg::ST_OK, 32'h0, 32'h0};
    localparam arlt_pkg::t_out_item RES_MISS = '{arlt_pkg::ST_MISS, 32'h0, 32'h0};

    typedef struct {
        bit                  typed;
        arlt_pkg::t_in_item  item;
        arlt_pkg::t_out_item result;
    } t_stim_row;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic                o_in_stall;
    arlt_pkg::t_in_item  i_in_item   = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    arlt_pkg::t_out_item o_out_item;

    bit                  region_valid  [arlt_pkg::ENTRIES];
    logic [31:0]         region_handle [arlt_pkg::ENTRIES];
    logic [31:0]         region_base   [arlt_pkg::ENTRIES];
    logic [31:0]         region_size   [arlt_pkg::ENTRIES];
    arlt_pkg::t_out_item pending_results [$];
    arlt_pkg::t_out_item want_result;

    int errors     = 0;
    int cycles     = 0;
    int stall_left = 0;
    int n_load     = 0;
    int n_full     = 0;
    int n_unload   = 0;
    int n_lookup   = 0;
    int n_hit      = 0;
    int n_spare    = 0;
    int n_checked  = 0;
    bit calm       = 1'b0;

    t_stim_row directed_rows [NUM_DIRECTED] = '{
        '{1'b1, '{arlt_pkg::OP_LOOKUP, 32'h0, 32'h0, 32'h0, 32'h0}, RES_MISS},
        '{1'b1, '{arlt_pkg::OP_UNLOAD, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0}, RES_MISS},
        '{1'b1, '{OP_SPARE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
          RES_MISS},
        '{1'b1, '{arlt_pkg::OP_LOAD, 32'h0, 32'h0, 32'h0, 32'h0}, RES_DONE},
        '{1'b0, '{arlt_pkg::OP_LOOKUP, 32'h0, 32'h0, 32'h0, 32'h0}, RES_DONE},
        '{1'b0, '{arlt_pkg::OP_LOOKUP, 32'h0, 32'h0, 32'h0, 32'h1}, RES_DONE},
        '{1'b1, '{arlt_pkg::OP_LOAD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  32'h0}, RES_DONE},
        '{1'b0, '{arlt_pkg::OP_LOOKUP, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF}, RES_DONE},
        '{1'b1, '{arlt_pkg::OP_LOAD, 32'h0000_00C0, 32'h1000, 32'h100, 32'h0}, RES_DONE},
        '{1'b1, '{arlt_pkg::OP_LOAD, 32'h0000_00C0, 32'h1080, 32'h10, 32'h0}, RES_DONE},
        '{1'b1, '{arlt_pkg::OP_LOAD, 32'h0000_00D0, 32'h1000, 32'h200, 32'h0}, RES_DONE},
        '{1'b0, '{arlt_pkg::OP_LOOKUP, 32'h0, 32'h0, 32'h0, 32'h1085}, RES_DONE},
        '{1'b0, '{arlt_pkg::OP_LOOKUP, 32'h0, 32'h0, 32'h0, 32'h1100}, RES_DONE},
        '{1'b0, '{arlt_pkg::OP_LOOKUP, 32'h0, 32'h0, 32'h0, 32'h1150}, RES_DONE},
        '{1'b0, '{arlt_pkg::OP_LOOKUP, 32'h0, 32'h0, 32'h0, 32'h1201}, RES_DONE},
        '{1'b1, '{arlt_pkg::OP_UNLOAD, 32'h0000_00C0, 32'h0, 32'h0, 32'h0}, RES_DONE},
        '{1'b1, '{arlt_pkg::OP_UNLOAD, 32'h0000_00C0, 32'h0, 32'h0, 32'h0}, RES_MISS},
        '{1'b0, '{arlt_pkg::OP_LOOKUP, 32'h0, 32'h0, 32'h0, 32'h1085}, RES_DONE},
        '{1'b1, '{arlt_pkg::OP_LOAD, 32'hAAAA_5555, 32'h8000_0000, 32'h7FFF_FFFF,
                  32'h0}, RES_DONE},
        '{1'b0, '{arlt_pkg::OP_LOOKUP, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF}, RES_DONE},
        '{1'b1, '{arlt_pkg::OP_UNLOAD, 32'h0, 32'h0, 32'h0, 32'h0}, RES_DONE},
        '{1'b1, '{arlt_pkg::OP_UNLOAD, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0}, RES_DONE},
        '{1'b1, '{arlt_pkg::OP_UNLOAD, 32'h0000_00D0, 32'h0, 32'h0, 32'h0}, RES_DONE}
    };

    address_region_lookup_table i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    always #5 i_clk = ~i_clk;

    function automatic arlt_pkg::t_out_item apply_table_op(arlt_pkg::t_in_item it);
        arlt_pkg::t_out_item res;
        int                  best;
        bit                  any;
        logic [32:0]         reach;
        res  = RES_MISS;
        best = -1;
        any  = 1'b0;
        case (it.opcode)
            arlt_pkg::OP_LOAD: begin
                res.status = arlt_pkg::ST_FULL;
                for (int s = 0; s < arlt_pkg::ENTRIES; s++) begin
                    if (!region_valid[s] && res.status == arlt_pkg::ST_FULL) begin
                        region_valid[s]  = 1'b1;
                        region_handle[s] = it.handle;
                        region_base[s]   = it.region_base;
                        region_size[s]   = it.region_size;
                        res.status       = arlt_pkg::ST_OK;
                    end
                end
            end
            arlt_pkg::OP_UNLOAD: begin
                for (int s = 0; s < arlt_pkg::ENTRIES; s++) begin
                    if (region_valid[s] && region_handle[s] == it.handle) begin
                        region_valid[s] = 1'b0;
                        any = 1'b1;
                    end
                end
                res.status = any ? arlt_pkg::ST_OK : arlt_pkg::ST_MISS;
            end
            arlt_pkg::OP_LOOKUP: begin
                for (int s = 0; s < arlt_pkg::ENTRIES; s++) begin
                    reach = {1'b0, region_base[s]} + {1'b0, region_size[s]};
                    if (region_valid[s] && region_base[s] <= it.address
                            && {1'b0, it.address} <= reach) begin
                        if (best < 0 || region_base[s] < region_base[best])
                            best = s;
                    end
                end
                if (best >= 0) begin
                    res.status       = arlt_pkg::ST_OK;
                    res.found_handle = region_handle[best];
                    res.offset       = it.address - region_base[best];
                end
            end
            default: res = RES_MISS;
        endcase
        return res;
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 55)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic int random_slot();
        int live [$];
        for (int s = 0; s < arlt_pkg::ENTRIES; s++)
            if (region_valid[s])
                live.insert(live.size(), s);
        if (live.size() == 0)
            return -1;
        return live[$urandom_range(0, live.size() - 1)];
    endfunction

    function automatic logic [31:0] pick_handle();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return $urandom_range(0, 15);
        if (roll < 80)
            return 32'hFFFF_FFFF - $urandom_range(0, 3);
        return $urandom;
    endfunction

    function automatic logic [31:0] pick_base();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 32'h0001_0000 + $urandom_range(0, 2047);
        if (roll < 70)
            return 32'hFFFF_F000 + $urandom_range(0, 4095);
        if (roll < 75)
            return 32'h0;
        return $urandom;
    endfunction

    function automatic logic [31:0] pick_size();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return $urandom_range(0, 255);
        if (roll < 75)
            return 32'h0;
        if (roll < 88)
            return $urandom;
        return 32'hFFFF_FFFF - $urandom_range(0, 15);
    endfunction

    function automatic logic [31:0] pick_address();
        int          s;
        logic [31:0] b;
        logic [31:0] z;
        s = random_slot();
        if (s < 0 || $urandom_range(0, 4) == 0) begin
            case ($urandom_range(0, 2))
                0: return 32'h0;
                1: return 32'hFFFF_FFFF;
                default: return $urandom;
            endcase
        end
        b = region_base[s];
        z = region_size[s];
        case ($urandom_range(0, 5))
            0: return b;
            1: return b + z;
            2: return b - 32'd1;
            3: return b + z + 32'd1;
            default: return b + $urandom_range(0, z);
        endcase
    endfunction

    function automatic arlt_pkg::t_in_item make_item(int mode);
        arlt_pkg::t_in_item it;
        int                 roll;
        int                 load_cut;
        int                 unload_cut;
        int                 s;
        it.handle      = pick_handle();
        it.region_base = $urandom;
        it.region_size = $urandom;
        it.address     = $urandom;
        case (mode)
            0: begin
                load_cut = 70;
                unload_cut = 80;
            end
            1: begin
                load_cut = 20;
                unload_cut = 70;
            end
            2: begin
                load_cut = 25;
                unload_cut = 35;
            end
            default: begin
                load_cut = 33;
                unload_cut = 58;
            end
        endcase
        roll = $urandom_range(0, 99);
        if (roll < load_cut) begin
            it.opcode      = arlt_pkg::OP_LOAD;
            it.region_base = pick_base();
            it.region_size = pick_size();
        end else if (roll < unload_cut) begin
            it.opcode = arlt_pkg::OP_UNLOAD;
            s = random_slot();
            if (s >= 0 && $urandom_range(0, 3) != 0)
                it.handle = region_handle[s];
        end else if (roll < 98) begin
            it.opcode  = arlt_pkg::OP_LOOKUP;
            it.address = pick_address();
        end else begin
            it.opcode = OP_SPARE;
        end
        return it;
    endfunction

    // Call at a falling edge; returns at the falling edge after the item is taken.
    task automatic send_item(arlt_pkg::t_in_item it, bit typed,
                             arlt_pkg::t_out_item typed_result);
        arlt_pkg::t_out_item predicted;
        int                  gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        predicted = apply_table_op(it);
        pending_results.insert(pending_results.size(), typed ? typed_result : predicted);
        case (it.opcode)
            arlt_pkg::OP_LOAD: begin
                n_load++;
                if (predicted.status == arlt_pkg::ST_FULL)
                    n_full++;
            end
            arlt_pkg::OP_UNLOAD: n_unload++;
            arlt_pkg::OP_LOOKUP: begin
                n_lookup++;
                if (predicted.status == arlt_pkg::ST_OK)
                    n_hit++;
            end
            default: n_spare++;
        endcase
        @(negedge i_clk);
    endtask

    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (pending_results.size() != 0);
    endtask

    initial begin
        forever begin
            @(negedge i_clk);
            if (stall_left == 0 && $urandom_range(0, 2) == 0)
                stall_left = pick_gap();
            i_out_stall <= (stall_left > 0);
            if (stall_left > 0)
                stall_left--;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall == 1'b0) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, status %0d handle %h offset %h",
                         $time, o_out_item.status, o_out_item.found_handle, o_out_item.offset);
                errors++;
            end else begin
                want_result = pending_results.pop_front();
                n_checked++;
                if (o_out_item.status !== want_result.status) begin
                    $display("%0t: status expected %0d, got %0d",
                             $time, want_result.status, o_out_item.status);
                    errors++;
                end
                if (o_out_item.found_handle !== want_result.found_handle) begin
                    $display("%0t: found_handle expected %h, got %h",
                             $time, want_result.found_handle, o_out_item.found_handle);
                    errors++;
                end
                if (o_out_item.offset !== want_result.offset) begin
                    $display("%0t: offset expected %h, got %h",
                             $time, want_result.offset, o_out_item.offset);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d results outstanding",
                     $time, cycles, pending_results.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        int                 count;
        int                 phase_len;
        int                 mode;
        bit                 drained;
        arlt_pkg::t_in_item it;
        count   = 0;
        drained = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        for (int r = 0; r < NUM_DIRECTED; r++)
            send_item(directed_rows[r].item, directed_rows[r].typed, directed_rows[r].result);
        wait_for_results();
        while (count < RANDOM_ITEMS) begin
            mode      = $urandom_range(0, 3);
            calm      = ($urandom_range(0, 3) == 0);
            phase_len = $urandom_range(40, 160);
            for (int k = 0; k < phase_len && count < RANDOM_ITEMS; k++) begin
                it = make_item(mode);
                send_item(it, 1'b0, RES_DONE);
                if (it.opcode != OP_SPARE)
                    count++;
            end
            // after the first phase, and at random after later ones, hold until the block has returned everything
            if (!drained || $urandom_range(0, 2) == 0) begin
                wait_for_results();
                drained = 1'b1;
            end
        end
        calm = 1'b0;
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("Run covered %0d loads (%0d refused on a full table), %0d unloads,",
                 n_load, n_full, n_unload);
        $display("%0d lookups (%0d hits), %0d unused opcodes; %0d results checked, %0d errors",
                 n_lookup, n_hit, n_spare, n_checked, errors);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== address_region_lookup_table.f =====
hdl/arlt_pkg.sv
hdl/arlt_ctrl.sv
hdl/arlt_dp.sv
hdl/address_region_lookup_table.sv
tb/address_region_lookup_table_test.sv
